@@ hw/rtl/imu_motion_phase_detector_top_defines.svh @@
// Assertion macros for the IMU motion phase detector.
// Included by the top level; needs clock and reset in scope.
`ifndef IMU_MOTION_PHASE_DETECTOR_TOP_DEFINES_SVH
`define IMU_MOTION_PHASE_DETECTOR_TOP_DEFINES_SVH
// implication checked on every clock outside reset
`define IMPD_ASSERT_IMPL(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define IMPD_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

@@ hw/rtl/impd_pkg.sv @@
// Shared types and constants of the IMU motion phase detector.
// No dependencies.
package impd_pkg;
   localparam int HOLD_SAMPLES_DEF = 2;
   localparam int MAX_GAP_MS_DEF = 120;
   localparam int STEP_PEAK_LEVEL_DEF = 655;
   localparam logic [15:0] ONE_G = 16'd4096;
   localparam logic [15:0] TAKEOFF_GYRO_MIN = 16'd448;
   localparam logic [10:0] EMA_NUM = 11'd1311;

   localparam logic [1:0] MODE_JUMP = 2'd0;
   localparam logic [1:0] MODE_SWING = 2'd1;
   localparam logic [1:0] MODE_STEP = 2'd2;
   localparam logic [1:0] MODE_SIT = 2'd3;

   localparam logic [2:0] PH_REST = 3'd0;
   localparam logic [2:0] PH_PRIMARY = 3'd1;
   localparam logic [2:0] PH_SECONDARY = 3'd2;
   localparam logic [2:0] PH_TAKEOFF = 3'd3;
   localparam logic [2:0] PH_FLIGHT = 3'd4;
   localparam logic [2:0] PH_LANDING = 3'd5;
   localparam logic [2:0] PH_RECOVERY = 3'd6;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_TIME = 2'd1;
   localparam logic [1:0] ST_GAP = 2'd2;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_TOL = 3'd1;
   localparam logic [2:0] REG_GLIM = 3'd2;
   localparam logic [2:0] REG_LEARN = 3'd3;
   localparam logic [2:0] REG_REV = 3'd4;
   localparam logic [2:0] REG_TAKE = 3'd5;
   localparam logic [2:0] REG_LAND = 3'd6;
   localparam logic [2:0] REG_FLY = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] tol;
      logic [15:0] glim;
      logic [15:0] learn;
      logic [15:0] rev;
      logic [15:0] take;
      logic [15:0] land;
      logic [15:0] fly;
   } cfg_type;

   typedef struct packed {
      logic load;    // latch sample, start sqrt
      logic sq_step; // one sqrt iteration
      logic dot;     // dot product terms
      logic decide;  // update state, build result
   } cmd_type;

   typedef struct packed {
      logic sq_done;
   } stat_type;
endpackage

@@ hw/rtl/impd_if.sv @@
// Valid/ready channel carrying one item.
// Uses no package.
interface impd_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/imu_motion_phase_detector_top.sv @@
// IMU motion phase detector.
// Channels req (sample in) and rsp (result out), one item each per handshake.
// The req item is {timestamp_ms, accel_z, accel_y, accel_x, gyro_z, gyro_y,
// gyro_x}, gyro_x in the low bits; rsp is {status, gyro_magnitude,
// accel_magnitude, peak flag, code valid flag, phase_code}.
// Registers are written over the csr_ APB-style port, 4 bytes apart.
// One item at a time: after acceptance the two square roots run 17 shared
// iteration steps until both finish, then the dot product is formed and the
// decision made, and the result is then offered. The next item is accepted
// only after the result has been taken.
// While rsp is stalled the result holds and req stays not ready.
// Reset clears all detector state and loads the register defaults.
`include "imu_motion_phase_detector_top_defines.svh"
module imu_motion_phase_detector_top
   import impd_pkg::*;
#(
   parameter int HOLD_SAMPLES = HOLD_SAMPLES_DEF,
   parameter int MAX_GAP_MS = MAX_GAP_MS_DEF,
   parameter int STEP_PEAK_LEVEL = STEP_PEAK_LEVEL_DEF
) (
   input  logic        clock,
   input  logic        reset,
   impd_if.sink        req,
   impd_if.source      rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   cfg_type cfg;
   cmd_type cmd;
   stat_type stat;

   impd_csr u_csr (.clock, .reset, .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .pready(csr_pready), .cfg);

   impd_ctrl u_ctrl (.clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .stat, .cmd);

   impd_dp #(.HOLD_SAMPLES(HOLD_SAMPLES), .MAX_GAP_MS(MAX_GAP_MS),
      .STEP_PEAK_LEVEL(STEP_PEAK_LEVEL)) u_dp (.clock, .reset, .cmd, .stat, .cfg,
      .in_data(req.data), .out_data(rsp.data));

   `IMPD_ASSERT_IMPL(a_no_overlap, req.ready, !rsp.valid)
   `IMPD_ASSERT_NEXT(a_load_starts, req.valid && req.ready, !req.ready && !rsp.valid)
   `IMPD_ASSERT_IMPL(a_rest_code, rsp.valid && !rsp.data[3], rsp.data[2:0] == PH_REST)
endmodule

@@ hw/rtl/impd_ctrl.sv @@
// Sequencer of the phase detector: load, sqrt iterations, dot, decide, output.
// Depends on impd_pkg.
module impd_ctrl
   import impd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   output logic     out_valid,
   input  logic     out_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_SQRT = 5'b00010, S_DOT = 5'b00100,
      S_DEC = 5'b01000, S_OUT = 5'b10000
   } state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sq_step = 1'b1;
            if (stat.sq_done) state_in = S_DOT;
         end
         S_DOT: begin
            cmd.dot = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

@@ hw/rtl/impd_dp.sv @@
// Datapath: two shared-step square roots, dot product, detector state.
// Depends on impd_pkg.
module impd_dp
   import impd_pkg::*;
#(
   parameter int HOLD_SAMPLES = HOLD_SAMPLES_DEF,
   parameter int MAX_GAP_MS = MAX_GAP_MS_DEF,
   parameter int STEP_PEAK_LEVEL = STEP_PEAK_LEVEL_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  cfg_type      cfg,
   input  logic [127:0] in_data,
   output logic [38:0]  out_data
);
   localparam logic [2:0] HOLD_INIT = 3'((HOLD_SAMPLES - 1) & 7);
   localparam logic [31:0] GAP = 32'(MAX_GAP_MS);
   localparam logic signed [17:0] PEAK_LVL = 18'(STEP_PEAK_LEVEL);

   logic signed [15:0] s_ff [3];
   logic [31:0] ts_ff;
   logic [33:0] gn_ff, an_ff, gr_ff, ar_ff;
   logic [33:0] bit_ff;
   logic [15:0] gm, am;
   logic signed [33:0] p_ff [3];
   logic signed [15:0] lv_ff [3];
   logic [15:0] lm_ff;
   logic [2:0] stage_ff, hold_ff, held_ff;
   logic known_ff, seen_ff;
   logic [31:0] last_ff;
   logic [23:0] base_ff;
   logic signed [17:0] dp_ff, dp2_ff;
   logic [1:0] hist_ff;
   logic [38:0] out_ff;

   // squares summed in the first step, then the roots are built bit by bit in the iteration steps
   function automatic logic [33:0] sumsq(logic signed [15:0] a, logic signed [15:0] b,
                                          logic signed [15:0] c);
      logic [31:0] qa, qb, qc;
      qa = 32'(a * a); qb = 32'(b * b); qc = 32'(c * c);
      return 34'(qa) + 34'(qb) + 34'(qc);
   endfunction

   assign stat.sq_done = (bit_ff == 34'd0);
   assign gm = (gr_ff > 34'd65535) ? 16'hFFFF : gr_ff[15:0];
   assign am = (ar_ff > 34'd65535) ? 16'hFFFF : ar_ff[15:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) s_ff[i] <= in_data[16*i +: 16];
         ts_ff <= in_data[127:96];
         gn_ff <= sumsq(in_data[15:0], in_data[31:16], in_data[47:32]);
         an_ff <= sumsq(in_data[63:48], in_data[79:64], in_data[95:80]);
         gr_ff <= '0; ar_ff <= '0;
         bit_ff <= 34'h1 << 32;
      end else if (cmd.sq_step && bit_ff != 34'd0) begin
         if (gn_ff >= gr_ff + bit_ff) begin
            gn_ff <= gn_ff - (gr_ff + bit_ff); gr_ff <= (gr_ff >> 1) + bit_ff;
         end else gr_ff <= gr_ff >> 1;
         if (an_ff >= ar_ff + bit_ff) begin
            an_ff <= an_ff - (ar_ff + bit_ff); ar_ff <= (ar_ff >> 1) + bit_ff;
         end else ar_ff <= ar_ff >> 1;
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.dot) for (int i = 0; i < 3; i++) p_ff[i] <= 34'(s_ff[i] * lv_ff[i]);
   end

   // decision logic
   logic rest, takeoff;
   logic [16:0] dev;
   logic signed [35:0] dot, lim;
   logic [23:0] base_n;
   logic signed [25:0] diff;
   logic signed [36:0] prod;
   logic signed [17:0] dyn;
   logic [38:0] res;
   logic [2:0] ph; logic vld, pk; logic [1:0] st;
   logic [2:0] stage_n, hold_n, held_n; logic known_n, seen_n;
   logic [31:0] last_n; logic [1:0] hist_n; logic signed [17:0] dp_n, dp2_n;
   logic lv_wr;

   always_comb begin
      dev = (am >= ONE_G) ? 17'(am - ONE_G) : 17'(ONE_G - am);
      rest = dev <= 17'(cfg.tol) && gm <= cfg.glim;
      takeoff = am >= cfg.take && (gm >= TAKEOFF_GYRO_MIN || am >= cfg.land);
      dot = 36'(p_ff[0]) + 36'(p_ff[1]) + 36'(p_ff[2]);
      lim = -$signed({4'd0, 32'(cfg.rev * lm_ff)});
      ph = PH_REST; vld = 1'b0; pk = 1'b0; st = ST_OK;
      stage_n = stage_ff; hold_n = hold_ff; held_n = held_ff; known_n = known_ff;
      seen_n = seen_ff; last_n = last_ff; hist_n = hist_ff; dp_n = dp_ff; dp2_n = dp2_ff;
      base_n = base_ff; lv_wr = 1'b0; dyn = '0;
      diff = $signed({2'b0, am, 8'd0}) - $signed({2'b0, base_ff});
      prod = diff * $signed({1'b0, EMA_NUM});
      if (seen_ff && ts_ff <= last_ff) st = ST_TIME;
      else begin
         if (seen_ff && (ts_ff - last_ff) > GAP) begin
            st = ST_GAP; stage_n = '0; hold_n = '0; held_n = PH_REST; known_n = 1'b0;
            hist_n = '0; dp_n = '0; dp2_n = '0; base_n = '0;
            diff = $signed({2'b0, am, 8'd0}); prod = '0;
         end
         seen_n = 1'b1; last_n = ts_ff;
         if (st == ST_OK && hold_ff != 3'd0) begin
            ph = held_ff; vld = 1'b1; hold_n = hold_ff - 3'd1;
         end else if (st == ST_OK && cfg.mode == MODE_JUMP) begin
            if (stage_ff == 3'd0 && takeoff) begin stage_n = 3'd1; ph = PH_TAKEOFF; vld = 1'b1; end
            else if (stage_ff == 3'd1 && am <= cfg.fly) begin stage_n = 3'd2; ph = PH_FLIGHT; vld = 1'b1; end
            else if (stage_ff == 3'd2 && am >= cfg.land) begin stage_n = 3'd3; ph = PH_LANDING; vld = 1'b1; end
            else if (stage_ff == 3'd3 && rest) begin stage_n = 3'd4; ph = PH_RECOVERY; vld = 1'b1; end
            else if (stage_ff == 3'd4 && rest) begin stage_n = 3'd0; ph = PH_REST; vld = 1'b1; end
         end else if (st == ST_OK && cfg.mode == MODE_SWING) begin
            if (stage_ff == 3'd0 && gm >= cfg.learn) begin
               lv_wr = 1'b1; known_n = 1'b1; stage_n = 3'd1; ph = PH_PRIMARY; vld = 1'b1;
            end else if (known_ff && stage_ff == 3'd1 && lm_ff != 16'd0 && dot <= lim) begin
               stage_n = 3'd2; ph = PH_SECONDARY; vld = 1'b1;
            end else if (stage_ff == 3'd2 && rest) begin
               stage_n = 3'd0; known_n = 1'b0; ph = PH_REST; vld = 1'b1;
            end
         end else if (cfg.mode == MODE_STEP) begin
            // floor of prod/65536 rounded toward minus infinity
            if (st == ST_GAP || hist_ff == 2'd0) base_n = {am, 8'd0};
            else base_n = 24'(base_ff + 24'(prod >>> 16));
            dyn = $signed({2'b0, am}) - $signed({2'b0, base_n[23:8]});
            if (st == ST_OK && hist_ff >= 2'd2 && dp_ff > dp2_ff && dp_ff >= dyn
                && dp_ff >= PEAK_LVL) pk = 1'b1;
            dp2_n = (st == ST_GAP) ? 18'sd0 : dp_ff; dp_n = dyn;
            hist_n = (st == ST_GAP) ? 2'd1 : ((hist_ff < 2'd2) ? hist_ff + 2'd1 : hist_ff);
         end else if (st == ST_OK && cfg.mode == MODE_SIT) begin
            if (rest) vld = 1'b1;
         end
         // sit mode flags rest without holding it
         if (vld && hold_ff == 3'd0 && st == ST_OK && cfg.mode != MODE_SIT) begin
            held_n = ph; hold_n = HOLD_INIT;
         end
      end
      res = {st, gm, am, pk, vld, ph};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0; hold_ff <= '0; held_ff <= PH_REST; known_ff <= 1'b0;
         seen_ff <= 1'b0; last_ff <= '0; hist_ff <= '0; dp_ff <= '0; dp2_ff <= '0;
         base_ff <= '0; lm_ff <= '0;
         for (int i = 0; i < 3; i++) lv_ff[i] <= '0;
      end else if (cmd.decide) begin
         out_ff <= res;
         if (res[38:37] != ST_TIME) begin
            stage_ff <= stage_n; hold_ff <= hold_n; held_ff <= held_n; known_ff <= known_n;
            seen_ff <= seen_n; last_ff <= last_n; hist_ff <= hist_n; dp_ff <= dp_n;
            dp2_ff <= dp2_n; base_ff <= base_n;
            if (res[38:37] == ST_GAP) begin
               lm_ff <= '0;
               for (int i = 0; i < 3; i++) lv_ff[i] <= '0;
            end else if (lv_wr) begin
               lm_ff <= gm;
               for (int i = 0; i < 3; i++) lv_ff[i] <= s_ff[i];
            end
         end
      end
   end
   assign out_data = out_ff;
endmodule

@@ hw/rtl/impd_csr.sv @@
// APB-style register file for the detector configuration.
// Depends on impd_pkg.
module impd_csr
   import impd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);
   cfg_type cfg_ff;
   logic [2:0] idx;
   assign idx = paddr[4:2];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: 2'd3, tol: 12'd819, glim: 16'd480, learn: 16'd960,
                     rev: 16'd640, take: 16'd4915, land: 16'd5325, fly: 16'd2458};
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            REG_MODE:  cfg_ff.mode <= pwdata[1:0];
            REG_TOL:   cfg_ff.tol <= pwdata[11:0];
            REG_GLIM:  cfg_ff.glim <= pwdata[15:0];
            REG_LEARN: cfg_ff.learn <= pwdata[15:0];
            REG_REV:   cfg_ff.rev <= pwdata[15:0];
            REG_TAKE:  cfg_ff.take <= pwdata[15:0];
            REG_LAND:  cfg_ff.land <= pwdata[15:0];
            REG_FLY:   cfg_ff.fly <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MODE:  prdata = {30'd0, cfg_ff.mode};
         REG_TOL:   prdata = {20'd0, cfg_ff.tol};
         REG_GLIM:  prdata = {16'd0, cfg_ff.glim};
         REG_LEARN: prdata = {16'd0, cfg_ff.learn};
         REG_REV:   prdata = {16'd0, cfg_ff.rev};
         REG_TAKE:  prdata = {16'd0, cfg_ff.take};
         REG_LAND:  prdata = {16'd0, cfg_ff.land};
         REG_FLY:   prdata = {16'd0, cfg_ff.fly};
         default:   prdata = '0;
      endcase
   end
endmodule
